[sv/ehrs_pkg.sv]
// Shared types, field widths and codes for the event histogram rate store.
// No dependencies; every other source file but ehrs_ram.sv imports this package.
package ehrs_pkg;

  // Default geometry of the histogram.
  localparam int SLOT_COUNT_DEF      = 4;
  localparam int TOF_CHANNELS_DEF    = 1024;
  localparam int ENERGY_CHANNELS_DEF = 256;
  localparam int STORE_DEPTH_DEF     = SLOT_COUNT_DEF * TOF_CHANNELS_DEF * ENERGY_CHANNELS_DEF;

  // Field widths.
  localparam int SLOT_W   = 6;
  localparam int TOF_W    = 10;
  localparam int EN_W     = 8;
  localparam int VAL_W    = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 16;
  localparam int RATE_W   = 48;

  // Widest bin index over the whole parameter range (64 * 1024 * 256).
  localparam int IDX_MAX_W = 24;

  // One store word holds count, mass and m/q.
  localparam int RAM_W = COUNT_W + 2 * VAL_W;

  // Rate arithmetic: count * 1000 (ms per s), then Q16 shift.
  localparam int MS_PER_S   = 1000;
  localparam int MS_W       = 10;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = COUNT_W + MS_W;
  localparam int DIVIDEND_W = PROD_W + FRAC_W;
  localparam int DIVISOR_W  = TIME_W;
  localparam int DIV_CW     = $clog2(DIVIDEND_W + 1);

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_RECORDED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_READ     = 2'd2;

  // Input function codes.
  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef enum logic [1:0] {
    KIND_REC,
    KIND_DROP,
    KIND_READ,
    KIND_READ_BAD
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [IDX_MAX_W-1:0]   addr;
    logic [VAL_W-1:0]       mass;
    logic [VAL_W-1:0]       mq;
    logic                   norm;   // divide by the time span on readout
    logic [DIVISOR_W-1:0]   span;
  } cmd_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

[sv/ehrs_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on ehrs_pkg for field widths.
interface ehrs_in_if import ehrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [SLOT_W-1:0] slot;
  logic [TOF_W-1:0]  tof_channel;
  logic [EN_W-1:0]   energy_channel;
  logic [VAL_W-1:0]  mass_value;
  logic [VAL_W-1:0]  mq_value;
  logic [TIME_W-1:0] event_time;

  modport source (output valid, func, slot, tof_channel, energy_channel, mass_value,
                  mq_value, event_time, input ready);
  modport sink   (input valid, func, slot, tof_channel, energy_channel, mass_value,
                  mq_value, event_time, output ready);
endinterface

interface ehrs_out_if import ehrs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  bin_count;
  logic [RATE_W-1:0]   bin_rate;
  logic [VAL_W-1:0]    bin_mass;
  logic [VAL_W-1:0]    bin_mq;

  modport source (output valid, status, bin_count, bin_rate, bin_mass, bin_mq, input ready);
  modport sink   (input valid, status, bin_count, bin_rate, bin_mass, bin_mq, output ready);
endinterface

[sv/ehrs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module ehrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/ehrs_fifo.sv]
// Short command queue between the classifying front and the store sequencer.
// Depends on ehrs_pkg for cmd_t and the queue depth.
module ehrs_fifo import ehrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] fill_r, fill_nxt;

  function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
    logic [QUEUE_AW-1:0] r;
    if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full  = (fill_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (fill_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[sv/ehrs_front.sv]
// Front end: accepts input words, range-checks them, forms the bin index,
// keeps the first/last record times and snapshots the rate span for reads.
// Depends on ehrs_pkg and ehrs_in_if.
module ehrs_front import ehrs_pkg::*; #(
  parameter int SLOT_COUNT      = SLOT_COUNT_DEF,
  parameter int TOF_CHANNELS    = TOF_CHANNELS_DEF,
  parameter int ENERGY_CHANNELS = ENERGY_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ehrs_in_if.sink           in_if,
  input  logic [SLOT_W-1:0] first_norm_slot,
  input  logic              clearing,
  input  logic              q_full,
  output logic              push,
  output cmd_t              push_cmd
);

  localparam int ADDR_W = $clog2(SLOT_COUNT * TOF_CHANNELS * ENERGY_CHANNELS);
  localparam int PLANE  = TOF_CHANNELS * ENERGY_CHANNELS;
  localparam int SLOT_CW = SLOT_W + 1;
  localparam int TOF_CW  = TOF_W + 1;
  localparam int EN_CW   = EN_W + 1;

  logic [TIME_W-1:0] first_r, first_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic              seen_r, seen_nxt;

  logic              in_range;
  logic [ADDR_W-1:0] idx;
  logic [TIME_W:0]   diff;
  logic              span_pos;

  assign in_if.ready = !q_full && !clearing;
  assign push        = in_if.valid && in_if.ready;

  always_comb begin
    in_range = ({1'b0, in_if.slot} < SLOT_CW'(SLOT_COUNT)) &&
               ({1'b0, in_if.tof_channel} < TOF_CW'(TOF_CHANNELS)) &&
               ({1'b0, in_if.energy_channel} < EN_CW'(ENERGY_CHANNELS));
    // Valid only when in range; wraps harmlessly otherwise.
    idx = ADDR_W'(in_if.slot) * ADDR_W'(PLANE) +
          ADDR_W'(in_if.tof_channel) * ADDR_W'(ENERGY_CHANNELS) +
          ADDR_W'(in_if.energy_channel);
    diff     = {1'b0, last_r} - {1'b0, first_r};
    span_pos = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);

    push_cmd.addr = IDX_MAX_W'(idx);
    push_cmd.mass = in_if.mass_value;
    push_cmd.mq   = in_if.mq_value;
    push_cmd.span = diff[TIME_W-1:0];
    push_cmd.norm = span_pos && (in_if.slot >= first_norm_slot);
    if (in_if.func == FUNC_RECORD) begin
      push_cmd.kind = in_range ? KIND_REC : KIND_DROP;
    end else begin
      push_cmd.kind = in_range ? KIND_READ : KIND_READ_BAD;
    end

    first_nxt = first_r;
    last_nxt  = last_r;
    seen_nxt  = seen_r;
    // Every record, dropped or not, moves the time stamps.
    if (push && in_if.func == FUNC_RECORD) begin
      last_nxt = in_if.event_time;
      if (!seen_r) begin
        first_nxt = in_if.event_time;
        seen_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      last_r  <= '0;
      seen_r  <= 1'b0;
    end else begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

[sv/ehrs_div.sv]
// Restoring divider, one quotient bit per cycle, for the rate readout.
// Depends on ehrs_pkg for div_req_t / div_rsp_t and operand widths.
module ehrs_div import ehrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  den_r, den_nxt;
  logic [DIV_CW-1:0]     cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});

    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
      cnt_nxt  = DIV_CW'(DIVIDEND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Remainder stays below the divisor, so it fits DIVISOR_W bits.
      rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[sv/ehrs_back.sv]
// Back end: clears the bin store after reset, then pops commands and does the
// read-modify-write or readout, with the rate divider and the result register.
// Depends on ehrs_pkg, ehrs_out_if, ehrs_ram and ehrs_div.
module ehrs_back import ehrs_pkg::*; #(
  parameter int DEPTH = STORE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_t     q_head,
  input  logic     q_empty,
  output logic     q_pop,
  output logic     clearing,
  ehrs_out_if.source out_if
);

  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  cmd_t              cur_r, cur_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0]  mass_r, mass_nxt;
  logic [VAL_W-1:0]  mq_r, mq_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [RATE_W-1:0]   out_rate_r;
  logic [VAL_W-1:0]    out_mass_r;
  logic [VAL_W-1:0]    out_mq_r;

  logic                out_free;
  logic                out_load;
  logic [STATUS_W-1:0] res_status;
  logic                res_data;   // load the read payload, else zeros

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [RAM_W-1:0]  ram_rdata;
  logic [COUNT_W-1:0] rd_count;
  logic [VAL_W-1:0]  rd_mass;
  logic [VAL_W-1:0]  rd_mq;
  logic [COUNT_W-1:0] count_inc;
  logic [PROD_W-1:0] prod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ehrs_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_head.addr[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  ehrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign rd_count  = ram_rdata[RAM_W-1 -: COUNT_W];
  assign rd_mass   = ram_rdata[2*VAL_W-1 -: VAL_W];
  assign rd_mq     = ram_rdata[VAL_W-1:0];
  assign count_inc = (rd_count == {COUNT_W{1'b1}}) ? rd_count : rd_count + 1'b1;
  assign prod      = PROD_W'(rd_count) * PROD_W'(MS_PER_S);

  assign clearing = (state_r == ST_CLEAR);
  assign out_free = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cur_nxt      = cur_r;
    cnt_nxt      = cnt_r;
    mass_nxt     = mass_r;
    mq_nxt       = mq_r;
    rate_nxt     = rate_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = clr_addr_r;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {prod, {FRAC_W{1'b0}}};
    div_req.divisor  = cur_r.span;
    out_load     = 1'b0;
    res_status   = STATUS_READ;
    res_data     = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ram_re    = 1'b1;
          cur_nxt   = q_head;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        case (cur_r.kind)
          KIND_REC: begin
            if (out_free) begin
              ram_we     = 1'b1;
              ram_waddr  = cur_r.addr[ADDR_W-1:0];
              ram_wdata  = {count_inc, cur_r.mass, cur_r.mq};
              out_load   = 1'b1;
              res_status = STATUS_RECORDED;
              state_nxt  = ST_IDLE;
            end
          end
          KIND_DROP: begin
            if (out_free) begin
              out_load   = 1'b1;
              res_status = STATUS_DROPPED;
              state_nxt  = ST_IDLE;
            end
          end
          KIND_READ: begin
            cnt_nxt  = rd_count;
            mass_nxt = rd_mass;
            mq_nxt   = rd_mq;
            // Quotient is below 2^42, so it fits the 48-bit rate without saturation.
            if (cur_r.norm) begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV;
            end else begin
              rate_nxt  = RATE_W'({rd_count, {FRAC_W{1'b0}}});
              state_nxt = ST_DONE;
            end
          end
          default: begin
            if (out_free) begin
              out_load  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          rate_nxt  = RATE_W'(div_rsp.quotient);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          res_data  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    cnt_r  <= cnt_nxt;
    mass_r <= mass_nxt;
    mq_r   <= mq_nxt;
    rate_r <= rate_nxt;
    if (out_load) begin
      out_status_r <= res_status;
      out_count_r  <= res_data ? cnt_r  : '0;
      out_rate_r   <= res_data ? rate_r : '0;
      out_mass_r   <= res_data ? mass_r : '0;
      out_mq_r     <= res_data ? mq_r   : '0;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_status_r;
  assign out_if.bin_count = out_count_r;
  assign out_if.bin_rate  = out_rate_r;
  assign out_if.bin_mass  = out_mass_r;
  assign out_if.bin_mq    = out_mq_r;

endmodule

[sv/event_histogram_rate_store_core.sv]
// Event histogram rate store. Accepted words are written into the command queue;
// the back end takes one at a time from its head: a record or drop passes IDLE
// (pop, store read) and LOOK (store write, result load), an unscaled read IDLE,
// LOOK and DONE, a normalized read IDLE, LOOK, DIV (bit-serial divide) and DONE.
// After reset the store is cleared one word a cycle, SLOT_COUNT*TOF_CHANNELS*
// ENERGY_CHANNELS words (1048576 at defaults); no input is taken meanwhile.
module event_histogram_rate_store_core import ehrs_pkg::*; #(
  parameter int SLOT_COUNT      = SLOT_COUNT_DEF,
  parameter int TOF_CHANNELS    = TOF_CHANNELS_DEF,
  parameter int ENERGY_CHANNELS = ENERGY_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ehrs_in_if.sink           in_if,
  ehrs_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int STORE_DEPTH = SLOT_COUNT * TOF_CHANNELS * ENERGY_CHANNELS;
  localparam logic REG_FIRST_NORM_SLOT = 1'b0;   // word index, paddr[2]

  logic [SLOT_W-1:0] fns_r, fns_nxt;
  logic              cfg_wr;

  logic clearing;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_push_cmd;
  cmd_t q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    fns_nxt = fns_r;
    if (cfg_wr && paddr[2] == REG_FIRST_NORM_SLOT) begin
      fns_nxt = pwdata[SLOT_W-1:0];
    end
    if (paddr[2] == REG_FIRST_NORM_SLOT) begin
      prdata = CFG_DW'(fns_r);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fns_r <= '0;
    end else begin
      fns_r <= fns_nxt;
    end
  end

  ehrs_front #(
    .SLOT_COUNT      (SLOT_COUNT),
    .TOF_CHANNELS    (TOF_CHANNELS),
    .ENERGY_CHANNELS (ENERGY_CHANNELS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_if           (in_if),
    .first_norm_slot (fns_r),
    .clearing        (clearing),
    .q_full          (q_full),
    .push            (q_push),
    .push_cmd        (q_push_cmd)
  );

  ehrs_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  ehrs_back #(
    .DEPTH (STORE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_if   (out_if)
  );

endmodule

[sim/ehrs_histogram_checker.sv]
// Scoreboard for the event histogram rate store: watches the word channels and the
// register port, predicts every result and compares it. Depends on ehrs_pkg and the
// channel interfaces in ehrs_if.sv.
module ehrs_histogram_checker import ehrs_pkg::*; #(
  parameter int                SLOT_COUNT      = SLOT_COUNT_DEF,
  parameter int                TOF_CHANNELS    = TOF_CHANNELS_DEF,
  parameter int                ENERGY_CHANNELS = ENERGY_CHANNELS_DEF,
  parameter logic [CFG_AW-1:0] NORM_SLOT_ADDR  = '0
) (
  input  logic              clk,
  input  logic              rst_n,
  ehrs_in_if                in_ch,
  ehrs_out_if               out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] RATE_CEILING = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [RATE_W-1:0]   rate;
    logic [VAL_W-1:0]    mass;
    logic [VAL_W-1:0]    mq;
  } bin_result_t;

  // Sparse copy of the histogram; a bin that was never recorded reads as zero.
  logic [COUNT_W-1:0] count_by_bin [int unsigned];
  logic [VAL_W-1:0]   mass_by_bin  [int unsigned];
  logic [VAL_W-1:0]   mq_by_bin    [int unsigned];

  logic [TIME_W-1:0]  first_stamp = '0;
  logic [TIME_W-1:0]  last_stamp  = '0;
  logic               stamp_seen  = 1'b0;
  logic [SLOT_W-1:0]  norm_slot   = '0;

  bin_result_t        expected_results [$];
  int                 fails = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [RATE_W-1:0] bin_rate_of(logic [COUNT_W-1:0] cnt,
                                                    logic [SLOT_W-1:0] slot);
    longint      span;
    logic [63:0] r;
    span = longint'({32'd0, last_stamp}) - longint'({32'd0, first_stamp});
    if (span > 0 && slot >= norm_slot) begin
      r = ({48'd0, cnt} * 64'd65536 * 64'(MS_PER_S)) / 64'(span);
    end else begin
      r = {32'd0, cnt, 16'd0};
    end
    if (r > RATE_CEILING) r = RATE_CEILING;
    return r[RATE_W-1:0];
  endfunction

  // Applies one accepted word to the histogram and returns the result it must give.
  function automatic bin_result_t apply_word(logic func, logic [SLOT_W-1:0] slot,
                                             logic [TOF_W-1:0] tof, logic [EN_W-1:0] en,
                                             logic [VAL_W-1:0] mass, logic [VAL_W-1:0] mq,
                                             logic [TIME_W-1:0] stamp);
    bin_result_t        res;
    logic               in_range;
    int unsigned        idx;
    logic [COUNT_W-1:0] cnt;
    res      = '0;
    in_range = (slot < SLOT_COUNT) && (tof < TOF_CHANNELS) && (en < ENERGY_CHANNELS);
    idx      = (int'(slot) * TOF_CHANNELS + int'(tof)) * ENERGY_CHANNELS + int'(en);
    cnt      = (in_range && count_by_bin.exists(idx)) ? count_by_bin[idx] : '0;
    if (func == FUNC_RECORD) begin
      // dropped records still move the time window
      if (!stamp_seen) begin
        first_stamp = stamp;
        stamp_seen  = 1'b1;
      end
      last_stamp = stamp;
      if (in_range) begin
        if (cnt != '1) cnt = cnt + 1'b1;
        count_by_bin[idx] = cnt;
        mass_by_bin[idx]  = mass;
        mq_by_bin[idx]    = mq;
        res.status        = STATUS_RECORDED;
      end else begin
        res.status = STATUS_DROPPED;
      end
    end else begin
      res.status = STATUS_READ;
      if (in_range && count_by_bin.exists(idx)) begin
        res.count = cnt;
        res.rate  = bin_rate_of(cnt, slot);
        res.mass  = mass_by_bin[idx];
        res.mq    = mq_by_bin[idx];
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bin_result_t want;
    if (!rst_n) begin
      count_by_bin.delete();
      mass_by_bin.delete();
      mq_by_bin.delete();
      expected_results.delete();
      first_stamp = '0;
      last_stamp  = '0;
      stamp_seen  = 1'b0;
      norm_slot   = '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == NORM_SLOT_ADDR) begin
        norm_slot = pwdata[SLOT_W-1:0];
      end
      // results never leave in the cycle their word arrives, so compare before queuing
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t ns: unexpected result word, expected none, actual status %0d",
                   $time, out_ch.status);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_ch.status));
          check_field("bin_count", 64'(want.count), 64'(out_ch.bin_count));
          check_field("bin_rate", 64'(want.rate), 64'(out_ch.bin_rate));
          check_field("bin_mass", 64'(want.mass), 64'(out_ch.bin_mass));
          check_field("bin_mq", 64'(want.mq), 64'(out_ch.bin_mq));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.insert(expected_results.size(),
                                apply_word(in_ch.func, in_ch.slot, in_ch.tof_channel,
                                           in_ch.energy_channel, in_ch.mass_value,
                                           in_ch.mq_value, in_ch.event_time));
      end
    end
    fail_count <= fails;
    pending    <= expected_results.size();
  end

endmodule

[sim/event_histogram_rate_store_core_test.sv]
// Top of the histogram rate store testbench: clock, reset, word stimulus, register
// writes and the verdict. Depends on ehrs_pkg, ehrs_if.sv, the core and the checker.
module event_histogram_rate_store_core_test import ehrs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // The limit leaves room for clearing the whole store after reset.
  localparam int                CYCLE_LIMIT         = 4_000_000;
  localparam int                TAIL_CYCLES         = 64;
  localparam int                POOL_SIZE           = 8;
  localparam int                PHASE_WORDS         = 250;
  localparam logic [CFG_AW-1:0] REG_FIRST_NORM_SLOT = 3'd0;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot;
    logic [TOF_W-1:0]  tof;
    logic [EN_W-1:0]   en;
    logic [VAL_W-1:0]  mass;
    logic [VAL_W-1:0]  mq;
    logic [TIME_W-1:0] stamp;
  } hist_word_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int                fail_count;
  int                pending;
  int                cycle_count = 0;
  int                send_idle_pct;
  int                recv_stall_pct;
  logic [TIME_W-1:0] stamp_clock;

  // Bins that most random words hit, so counts build up and reads see them.
  logic [SLOT_W-1:0] pool_slot [POOL_SIZE];
  logic [TOF_W-1:0]  pool_tof  [POOL_SIZE];
  logic [EN_W-1:0]   pool_en   [POOL_SIZE];

  ehrs_in_if  in_ch ();
  ehrs_out_if out_ch ();

  event_histogram_rate_store_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ehrs_histogram_checker #(
    .NORM_SLOT_ADDR (REG_FIRST_NORM_SLOT)
  ) hist_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic hist_word_t make_word(logic func, logic [SLOT_W-1:0] slot,
                                           logic [TOF_W-1:0] tof, logic [EN_W-1:0] en,
                                           logic [VAL_W-1:0] mass, logic [VAL_W-1:0] mq,
                                           logic [TIME_W-1:0] stamp);
    hist_word_t w;
    w.func  = func;
    w.slot  = slot;
    w.tof   = tof;
    w.en    = en;
    w.mass  = mass;
    w.mq    = mq;
    w.stamp = stamp;
    return w;
  endfunction

  function automatic hist_word_t random_word();
    hist_word_t w;
    int         pick;
    int         k;
    w.func = ($urandom_range(99) < 35) ? FUNC_READ : FUNC_RECORD;
    pick   = $urandom_range(99);
    if (pick < 70) begin
      k      = $urandom_range(POOL_SIZE - 1);
      w.slot = pool_slot[k];
      w.tof  = pool_tof[k];
      w.en   = pool_en[k];
    end else begin
      // a few words go past the slot range to hit drops and bad reads
      w.slot = (pick < 88) ? SLOT_W'($urandom_range(SLOT_COUNT_DEF - 1))
                           : SLOT_W'($urandom_range(63));
      w.tof  = TOF_W'($urandom_range(1023));
      w.en   = EN_W'($urandom_range(255));
    end
    w.mass = VAL_W'($urandom_range(65535));
    w.mq   = VAL_W'($urandom_range(65535));
    pick   = $urandom_range(99);
    if (pick < 88) stamp_clock = stamp_clock + $urandom_range(1, 4000);
    else if (pick < 94) stamp_clock = $urandom;
    else stamp_clock = stamp_clock - $urandom_range(5000);
    w.stamp = (w.func == FUNC_RECORD) ? stamp_clock : TIME_W'($urandom);
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input hist_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.func           = w.func;
    in_ch.slot           = w.slot;
    in_ch.tof_channel    = w.tof;
    in_ch.energy_channel = w.en;
    in_ch.mass_value     = w.mass;
    in_ch.mq_value       = w.mq;
    in_ch.event_time     = w.stamp;
    in_ch.valid          = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    int phase_idle  [4];
    int phase_stall [4];
    int phase_norm  [4];
    phase_idle  = '{0, 56, 0, 9};
    phase_stall = '{0, 0, 56, 9};
    phase_norm  = '{3, 0, 1, 63};

    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_ch.valid          = 1'b0;
    in_ch.func           = FUNC_RECORD;
    in_ch.slot           = '0;
    in_ch.tof_channel    = '0;
    in_ch.energy_channel = '0;
    in_ch.mass_value     = '0;
    in_ch.mq_value       = '0;
    in_ch.event_time     = '0;
    out_ch.ready         = 1'b1;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    stamp_clock          = 32'd4000;

    pool_slot[0] = '0;
    pool_tof[0]  = '0;
    pool_en[0]   = '0;
    pool_slot[1] = SLOT_W'(SLOT_COUNT_DEF - 1);
    pool_tof[1]  = '1;
    pool_en[1]   = '1;
    for (int k = 2; k < POOL_SIZE; k++) begin
      pool_slot[k] = SLOT_W'($urandom_range(SLOT_COUNT_DEF - 1));
      pool_tof[k]  = TOF_W'($urandom_range(1023));
      pool_en[k]   = EN_W'($urandom_range(255));
    end

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    write_register(REG_FIRST_NORM_SLOT, 32'd0);

    // empty bin read with no time window yet
    send_word(make_word(FUNC_READ, 6'd0, 10'd0, 8'd0, 16'h0000, 16'h0000, 32'd0));
    // first record is dropped but still opens the time window
    send_word(make_word(FUNC_RECORD, 6'd63, 10'd1023, 8'd255, 16'hFFFF, 16'hFFFF, 32'd1000));
    send_word(make_word(FUNC_READ, 6'd63, 10'd1023, 8'd255, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(make_word(FUNC_RECORD, 6'd0, 10'd0, 8'd0, 16'h0000, 16'h0000, 32'd1000));
    // zero span: unscaled
    send_word(make_word(FUNC_READ, 6'd0, 10'd0, 8'd0, 16'h0000, 16'h0000, 32'd0));
    send_word(make_word(FUNC_RECORD, 6'd3, 10'd1023, 8'd255, 16'hFFFF, 16'h0000, 32'd1500));
    send_word(make_word(FUNC_RECORD, 6'd3, 10'd1023, 8'd255, 16'h1234, 16'hFFFF, 32'd3000));
    send_word(make_word(FUNC_READ, 6'd3, 10'd1023, 8'd255, 16'h0000, 16'h0000, 32'd0));
    // first slot past the histogram
    send_word(make_word(FUNC_RECORD, 6'd4, 10'd1, 8'd1, 16'hAAAA, 16'h5555, 32'd3001));
    send_word(make_word(FUNC_READ, 6'd0, 10'd0, 8'd0, 16'h0000, 16'h0000, 32'd0));
    // time going back before the first record: negative span, unscaled
    send_word(make_word(FUNC_RECORD, 6'd1, 10'd300, 8'd77, 16'h5555, 16'hAAAA, 32'd0));
    send_word(make_word(FUNC_READ, 6'd3, 10'd1023, 8'd255, 16'h0000, 16'h0000, 32'd0));
    send_word(make_word(FUNC_READ, 6'd1, 10'd300, 8'd77, 16'h0000, 16'h0000, 32'd0));
    // widest span
    send_word(make_word(FUNC_RECORD, 6'd2, 10'd512, 8'd128, 16'h8001, 16'h7FFE, 32'hFFFF_FFFF));
    send_word(make_word(FUNC_READ, 6'd2, 10'd512, 8'd128, 16'h0000, 16'h0000, 32'd0));
    // span of one millisecond gives the largest reachable rate
    send_word(make_word(FUNC_RECORD, 6'd0, 10'd0, 8'd0, 16'h0001, 16'h8000, 32'd1001));
    send_word(make_word(FUNC_READ, 6'd0, 10'd0, 8'd0, 16'h0000, 16'h0000, 32'd0));
    send_word(make_word(FUNC_READ, 6'd4, 10'd0, 8'd0, 16'h0000, 16'h0000, 32'd0));
    send_word(make_word(FUNC_READ, 6'd40, 10'd1023, 8'd255, 16'hFFFF, 16'hFFFF, 32'd0));

    drain_results();
    write_register(REG_FIRST_NORM_SLOT, 32'd63);
    send_word(make_word(FUNC_READ, 6'd0, 10'd0, 8'd0, 16'h0000, 16'h0000, 32'd0));
    send_word(make_word(FUNC_READ, 6'd3, 10'd1023, 8'd255, 16'h0000, 16'h0000, 32'd0));
    drain_results();
    write_register(REG_FIRST_NORM_SLOT, 32'd1);
    send_word(make_word(FUNC_READ, 6'd0, 10'd0, 8'd0, 16'h0000, 16'h0000, 32'd0));
    send_word(make_word(FUNC_READ, 6'd1, 10'd300, 8'd77, 16'h0000, 16'h0000, 32'd0));

    for (int p = 0; p < 4; p++) begin
      drain_results();
      write_register(REG_FIRST_NORM_SLOT, CFG_DW'(phase_norm[p]));
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // now and then hold off until the block has emptied
        if ($urandom_range(99) == 0) drain_results();
        send_word(random_word());
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ehrs_pkg.sv
sv/ehrs_if.sv
sv/ehrs_ram.sv
sv/ehrs_fifo.sv
sv/ehrs_front.sv
sv/ehrs_div.sv
sv/ehrs_back.sv
sv/event_histogram_rate_store_core.sv
sim/ehrs_histogram_checker.sv
sim/event_histogram_rate_store_core_test.sv
